FILE: rtl/wba_pkg.sv
package wba_pkg;

    localparam int PANO_WIDTH  = 1024;
    localparam int PANO_HEIGHT = 512;
    localparam int SUM_BITS    = 16;
    localparam int COL_BITS    = 10;
    localparam int ROW_BITS    = 9;
    localparam int ADDR_BITS   = COL_BITS + ROW_BITS;
    localparam int DEPTH       = 1 << ADDR_BITS;
    localparam int ENTRY_BITS  = 4 * SUM_BITS;
    localparam int QUOT_BITS   = 9;
    localparam int DIVD_BITS   = SUM_BITS + 8;

    localparam logic [0:0] REQ_ACC  = 1'b0;
    localparam logic [0:0] REQ_READ = 1'b1;

    typedef struct packed {
        logic [0:0]          req_type;
        logic [COL_BITS-1:0] col;
        logic [ROW_BITS-1:0] row;
        logic [7:0]          red;
        logic [7:0]          green;
        logic [7:0]          blue;
        logic [7:0]          weight;
    } req_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic       covered;
    } rsp_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_UPDATE,
        ST_DIVIDE,
        ST_OUTPUT
    } state_t;

    typedef struct packed {
        logic load_req;
        logic clear_step;
        logic write_back;
        logic div_start;
        logic div_step;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic clear_done;
        logic is_read;
        logic div_done;
        logic out_full;
    } sts_t;

    // floor(c*w/255) for 16-bit products, exact for any product of two 8-bit values (c*w <= 65025).
    function automatic logic [7:0] div255(input logic [15:0] p);
        logic [16:0] t;
        begin
            t = {1'b0, p} + 17'd1 + {9'd0, p[15:8]};
            div255 = t[15:8];
        end
    endfunction

    function automatic logic [SUM_BITS-1:0] sat_add(input logic [SUM_BITS-1:0] a,
                                                    input logic [7:0] b);
        logic [SUM_BITS:0] s;
        begin
            s = {1'b0, a} + {{(SUM_BITS-7){1'b0}}, b};
            sat_add = s[SUM_BITS] ? {SUM_BITS{1'b1}} : s[SUM_BITS-1:0];
        end
    endfunction

endpackage

FILE: rtl/wba_stream_if.sv
interface wba_stream_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: rtl/wba_ram.sv
module wba_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/wba_ctrl.sv
module wba_ctrl (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         in_valid,
    output logic         in_ready,
    input  wba_pkg::sts_t sts,
    output wba_pkg::cmd_t cmd
);
    import wba_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_step = 1'b1;
                if (sts.clear_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_req = 1'b1;
                    state_next   = ST_FETCH;
                end
            end
            ST_FETCH:
            begin
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                if (sts.is_read)
                begin
                    cmd.div_start = 1'b1;
                    state_next    = ST_DIVIDE;
                end
                else
                begin
                    cmd.write_back = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_DIVIDE:
            begin
                if (sts.div_done)
                begin
                    if (!sts.out_full)
                    begin
                        cmd.out_load = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                else
                begin
                    cmd.div_step = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end
endmodule

FILE: rtl/wba_datapath.sv
module wba_datapath (
    input  logic          clk,
    input  logic          rst_n,
    input  wba_pkg::req_t req,
    input  wba_pkg::cmd_t cmd,
    output wba_pkg::sts_t sts,
    output logic          out_valid,
    input  logic          out_ready,
    output wba_pkg::rsp_t rsp
);
    import wba_pkg::*;

    localparam int CNT_BITS = $clog2(QUOT_BITS + 1);

    req_t                  req_reg;
    logic [ADDR_BITS:0]    clr_reg;
    logic [ENTRY_BITS-1:0] rdata;
    logic [ENTRY_BITS-1:0] wdata;
    logic [ADDR_BITS-1:0]  waddr;
    logic [ADDR_BITS-1:0]  addr;
    logic                  we;
    logic                  in_pano;
    logic [SUM_BITS-1:0]   s_r, s_g, s_b, s_w;
    logic [15:0]           p_r, p_g, p_b;
    logic [ENTRY_BITS-1:0] upd;
    logic [DIVD_BITS-1:0]  prod [3];
    logic [SUM_BITS-1:0]   den;

    // Three restoring dividers run side by side, one quotient bit per cycle.
    logic [DIVD_BITS-1:0]  num_reg [3];
    logic [SUM_BITS:0]     rem_reg [3];
    logic [QUOT_BITS-1:0]  quo_reg [3];
    logic [2:0]            ovf_reg;
    logic [SUM_BITS-1:0]   den_reg;
    logic                  cov_reg;
    logic [CNT_BITS-1:0]   cnt_reg;
    logic                  busy_reg;
    rsp_t                  rsp_reg;
    logic                  out_valid_reg;

    assign addr    = {req_reg.row, req_reg.col};
    assign in_pano = (32'(req_reg.col) < PANO_WIDTH) && (32'(req_reg.row) < PANO_HEIGHT);

    assign s_r = rdata[4*SUM_BITS-1:3*SUM_BITS];
    assign s_g = rdata[3*SUM_BITS-1:2*SUM_BITS];
    assign s_b = rdata[2*SUM_BITS-1:SUM_BITS];
    assign s_w = rdata[SUM_BITS-1:0];
    assign p_r = 16'(req_reg.red) * 16'(req_reg.weight);
    assign p_g = 16'(req_reg.green) * 16'(req_reg.weight);
    assign p_b = 16'(req_reg.blue) * 16'(req_reg.weight);
    assign upd = {sat_add(s_r, div255(p_r)), sat_add(s_g, div255(p_g)),
                  sat_add(s_b, div255(p_b)), sat_add(s_w, req_reg.weight)};

    // sum*255 = (sum << 8) - sum.
    assign prod[0] = {s_r, 8'd0} - DIVD_BITS'(s_r);
    assign prod[1] = {s_g, 8'd0} - DIVD_BITS'(s_g);
    assign prod[2] = {s_b, 8'd0} - DIVD_BITS'(s_b);
    assign den     = in_pano ? s_w : '0;

    assign we    = cmd.clear_step || (cmd.write_back && in_pano);
    assign waddr = cmd.clear_step ? clr_reg[ADDR_BITS-1:0] : addr;
    assign wdata = cmd.clear_step ? '0 : upd;

    wba_ram #(.WIDTH(ENTRY_BITS), .DEPTH(DEPTH)) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (addr),
        .rdata (rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_req)
        begin
            req_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_reg <= '0;
        end
        else if (cmd.clear_step && !clr_reg[ADDR_BITS])
        begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (cmd.div_start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNT_BITS'(QUOT_BITS);
        end
        else if (cmd.div_step)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            den_reg <= den;
            cov_reg <= in_pano && (s_w != '0);
            // The upper dividend bits preload the remainder, so only the low
            // QUOT_BITS bits are shifted in. If that preload already reaches
            // the divisor, the quotient does not fit and the color clamps.
            for (int k = 0; k < 3; k++)
            begin
                rem_reg[k] <= {2'b00, prod[k][DIVD_BITS-1:QUOT_BITS]};
                num_reg[k] <= {prod[k][QUOT_BITS-1:0], {(DIVD_BITS-QUOT_BITS){1'b0}}};
                quo_reg[k] <= '0;
                ovf_reg[k] <= ({1'b0, prod[k][DIVD_BITS-1:QUOT_BITS]} >= den);
            end
        end
        else if (cmd.div_step)
        begin
            for (int k = 0; k < 3; k++)
            begin
                logic [SUM_BITS+1:0] trial;
                logic [SUM_BITS:0]   rs;
                trial = {rem_reg[k], num_reg[k][DIVD_BITS-1]};
                rs    = trial[SUM_BITS:0];
                if (trial >= {2'b00, den_reg})
                begin
                    rs = {1'b0, SUM_BITS'(trial - {2'b00, den_reg})};
                    quo_reg[k] <= {quo_reg[k][QUOT_BITS-2:0], 1'b1};
                end
                else
                begin
                    quo_reg[k] <= {quo_reg[k][QUOT_BITS-2:0], 1'b0};
                end
                rem_reg[k] <= rs;
                num_reg[k] <= {num_reg[k][DIVD_BITS-2:0], 1'b0};
            end
        end
    end

    // An uncovered pixel reads as zero; a quotient above 255 clamps to 255.
    function automatic logic [7:0] clamp(input logic [QUOT_BITS-1:0] q, input logic o,
                                         input logic c);
        begin
            if (!c)
            begin
                clamp = '0;
            end
            else if (o || q[QUOT_BITS-1])
            begin
                clamp = 8'hFF;
            end
            else
            begin
                clamp = q[7:0];
            end
        end
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            rsp_reg.out_red   <= clamp(quo_reg[0], ovf_reg[0], cov_reg);
            rsp_reg.out_green <= clamp(quo_reg[1], ovf_reg[1], cov_reg);
            rsp_reg.out_blue  <= clamp(quo_reg[2], ovf_reg[2], cov_reg);
            rsp_reg.covered   <= cov_reg;
        end
    end

    assign sts.clear_done = clr_reg[ADDR_BITS];
    assign sts.is_read    = (req_reg.req_type == REQ_READ);
    assign sts.div_done   = !busy_reg;
    assign sts.out_full   = out_valid_reg && !out_ready;
    assign out_valid      = out_valid_reg;
    assign rsp            = rsp_reg;
endmodule

FILE: rtl/weighted_blend_accumulator.sv
// channel | dir | payload
// req     | in  | req_type, col, row, red, green, blue, weight
// rsp     | out | out_red, out_green, out_blue, covered
// After reset a clearing pass zeroes the store before req is ready.
// An accumulate goes through accept, RAM read and write back.
// A read goes through accept, RAM read, divider load, 9 divider steps and
// the output load; the divider does one quotient bit a cycle.
// A finished result waits in the output register while the next item is taken.
module weighted_blend_accumulator (
    input logic clk,
    input logic rst_n,
    wba_stream_if.sink   req,
    wba_stream_if.source rsp
);
    import wba_pkg::*;

    cmd_t cmd;
    sts_t sts;

    wba_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    wba_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req.data),
        .cmd       (cmd),
        .sts       (sts),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .rsp       (rsp.data)
    );

`ifndef SYNTHESIS
    a_no_load_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> !sts.out_full) else $error("result register overwritten");
    a_cov_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.data.covered) |-> (rsp.data.out_red == 8'd0))
        else $error("uncovered pixel with color");
    a_start_step: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !sts.div_done) else $error("divider did not start");
`endif
endmodule
